// ----- src/cvni_pkg.sv -----
// Package for the chord voicing block: payload types, configuration indexes,
// controller/datapath command and status bundles, a small lookup function.
// No dependencies.
package cvni_pkg;

    localparam int CHORD_SLOTS_DEF     = 4;
    localparam int MAX_DIGITS_DEF      = 8;
    localparam int INVERSION_COUNT_DEF = 11;
    localparam int NOTE_RANGE          = 128;
    localparam int STORED_DIGITS       = 8;
    localparam int CENT_W              = 16;
    localparam int CFG_IDX_W           = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LO = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HI = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ON    = 4'd7;

    localparam logic [63:0] RST_DIGITS   = 64'd4535485465632;
    localparam logic [15:0] RST_LENGTHS  = 16'd13107;
    localparam logic [47:0] RST_STEPS    = 48'd194466848;
    localparam logic [3:0]  RST_SCALE    = 4'd7;
    localparam logic [2:0]  RST_OCTAVE   = 3'd2;
    localparam logic [2:0]  RST_CYCLES   = 3'd1;

    typedef struct packed {
        logic signed [7:0] base_note;
        logic signed [7:0] slot_select;
    } t_in;

    typedef struct packed {
        logic [63:0] notes_low;
        logic [63:0] notes_high;
    } t_out;

    typedef struct packed {
        logic [63:0] digits_lo;
        logic [63:0] digits_hi;
        logic [15:0] lengths;
        logic [47:0] steps;
        logic [3:0]  scale_len;
        logic [2:0]  octave;
        logic [2:0]  cycles;
        logic        inv_on;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic job_init;
        logic cand_init;
        logic note_step;
        logic div_init;
        logic div_step;
        logic cmp;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic build_done;
        logic div_done;
        logic last_cand;
        logic out_free;
    } t_sts;

    // Scale entry for a digit: digit modulo scale length, as a constant table.
    function automatic logic [3:0] f_scale_entry(input logic [3:0] d, input logic [3:0] len);
        logic [3:0] r;
        int m;
        r = '0;
        for (int a = 0; a < 16; a++) begin
            for (int b = 1; b < 16; b++) begin
                m = a;
                for (int t = 0; t < 16; t++) begin
                    if (m >= b) m = m - b;
                end
                if (d == 4'(a) && len == 4'(b)) begin
                    r = 4'(m);
                end
            end
        end
        return r;
    endfunction

endpackage

// ----- src/cvni_ctrl.sv -----
// Sequencer for the chord voicing block: walks candidates, note build,
// centroid divide and compare. Depends on cvni_pkg.
module cvni_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cvni_pkg::t_sts   i_sts,
    output cvni_pkg::t_cmd   o_cmd
);
    import cvni_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_CAND, S_BUILD, S_DIV, S_CMP, S_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.job_init = 1'b1;
                    n_state        = S_CAND;
                end
            end
            S_CAND: begin
                o_cmd.cand_init = 1'b1;
                n_state         = S_BUILD;
            end
            S_BUILD: begin
                if (i_sts.build_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.note_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_CMP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.last_cand ? S_OUT : S_CAND;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/cvni_datapath.sv -----
// Datapath for the chord voicing block: note builder, note set with running
// sum and count, restoring divider, best-candidate registers, output register.
// Depends on cvni_pkg.
module cvni_datapath #(
    parameter int CHORD_SLOTS     = cvni_pkg::CHORD_SLOTS_DEF,
    parameter int MAX_DIGITS      = cvni_pkg::MAX_DIGITS_DEF,
    parameter int INVERSION_COUNT = cvni_pkg::INVERSION_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cvni_pkg::t_cfg   i_cfg,
    input  cvni_pkg::t_in    i_in,
    input  cvni_pkg::t_cmd   i_cmd,
    output cvni_pkg::t_sts   o_sts,
    output cvni_pkg::t_out   o_out,
    output logic             o_out_valid,
    input  logic             i_out_stall
);
    import cvni_pkg::*;

    localparam int SLOT_W  = (CHORD_SLOTS > 1) ? $clog2(CHORD_SLOTS) : 1;
    localparam int LEN_CAP = (MAX_DIGITS < STORED_DIGITS) ? MAX_DIGITS : STORED_DIGITS;
    localparam int HALF    = INVERSION_COUNT / 2;
    localparam int CAND_W  = $clog2(INVERSION_COUNT + 1);
    localparam int DIV_N   = 21;

    function automatic logic [SLOT_W-1:0] f_slot(input logic signed [7:0] s);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int k = -128; k < 128; k++) begin
            if (s == 8'(k)) begin
                r = SLOT_W'(((k % CHORD_SLOTS) + CHORD_SLOTS) % CHORD_SLOTS);
            end
        end
        return r;
    endfunction

    // Position of the lowest inversion: remainder of -HALF by len.
    function automatic logic [2:0] f_start_idx(input logic [3:0] len);
        int r;
        r = -HALF;
        for (int j = 0; j < 8; j++) begin
            if (r < 0) r = r + int'(len);
        end
        return 3'(r);
    endfunction

    // Octave of the lowest inversion; octaves count from one above the root.
    function automatic logic signed [7:0] f_start_oct(input logic [3:0] len);
        int r;
        int o;
        r = -HALF;
        o = 1;
        for (int j = 0; j < 8; j++) begin
            if (r < 0) begin
                r = r + int'(len);
                o = o - 1;
            end
        end
        return 8'(o);
    endfunction

    // item and job registers
    logic signed [7:0]  r_base;
    logic [SLOT_W-1:0]  r_slot;
    logic [3:0]         r_len;
    logic [31:0]        r_digits;
    logic [3:0]         r_sclen;
    logic [CAND_W-1:0]  r_cand;
    logic [2:0]         r_sidx;
    logic signed [7:0]  r_soct;
    // candidate build
    logic [2:0]         r_idx;
    logic signed [7:0]  r_oct;
    logic [6:0]         r_rem;
    logic [127:0]       r_set;
    logic [12:0]        r_sum;
    logic [7:0]         r_cnt;
    // divider
    logic [DIV_N-1:0]   r_dq;
    logic [7:0]         r_drem;
    logic [4:0]         r_dcnt;
    // best candidate, history, output
    logic [CENT_W-1:0]  r_best_dist;
    logic [CENT_W-1:0]  r_best_cent;
    logic [127:0]       r_best_set;
    logic [CENT_W-1:0]  r_last_cent;
    t_out               r_out;
    logic               r_out_valid;

    logic [1:0]         w_slot2;
    logic               w_slot_ok;
    logic [3:0]         w_len_raw;
    logic [3:0]         w_len;
    logic [63:0]        w_pair;
    logic               w_search;
    logic [3:0]         w_sclen;
    logic [3:0]         w_digit;
    logic [3:0]         w_entry;
    logic [3:0]         w_step;
    logic signed [11:0] w_oct_ext;
    logic signed [11:0] w_note;
    logic               w_new;
    logic [8:0]         w_trial;
    logic               w_ge;
    logic [CENT_W-1:0]  w_cc;
    logic [CENT_W-1:0]  w_dist;
    logic [6:0]         w_oct2;
    logic [6:0]         w_shamt;
    logic [127:0]       w_shifted;

    assign w_slot2   = 2'(r_slot);
    assign w_slot_ok = (32'(r_slot) < 32'd4);
    assign w_len_raw = i_cfg.lengths[4*w_slot2 +: 4];
    assign w_len     = (w_len_raw > 4'(LEN_CAP)) ? 4'(LEN_CAP) : w_len_raw;
    assign w_pair    = w_slot2[1] ? i_cfg.digits_hi : i_cfg.digits_lo;
    assign w_search  = i_cfg.inv_on && (r_last_cent > 16'd2);
    assign w_sclen   = (i_cfg.scale_len == 4'd0) ? 4'd1 :
                       (i_cfg.scale_len > 4'd12) ? 4'd12 : i_cfg.scale_len;

    assign w_digit   = r_digits[4*r_idx +: 4];
    assign w_entry   = f_scale_entry(w_digit, r_sclen);
    assign w_step    = i_cfg.steps[4*w_entry +: 4];
    assign w_oct_ext = 12'(r_oct);
    assign w_note    = $signed({8'd0, w_step}) + 12'(r_base)
                     + (w_oct_ext <<< 3) + (w_oct_ext <<< 2);
    assign w_new     = !w_note[11] && (w_note[10:7] == 4'd0) && !r_set[w_note[6:0]];

    assign w_trial   = {r_drem, r_dq[DIV_N-1]};
    assign w_ge      = (w_trial >= {1'b0, r_cnt});
    assign w_cc      = (r_cnt == 8'd0) ? '0 : r_dq[CENT_W-1:0];
    assign w_dist    = (w_cc > r_last_cent) ? w_cc - r_last_cent : r_last_cent - w_cc;

    assign w_oct2    = 7'(i_cfg.octave) + 7'd2;
    assign w_shamt   = (w_oct2 << 3) + (w_oct2 << 2);
    assign w_shifted = r_best_set << w_shamt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_in.base_note;
            r_slot <= f_slot(i_in.slot_select);
        end
        if (i_cmd.job_init) begin
            r_len       <= w_len;
            r_digits    <= w_slot2[0] ? w_pair[63:32] : w_pair[31:0];
            r_sclen     <= w_sclen;
            r_cand      <= w_search ? CAND_W'(INVERSION_COUNT) : CAND_W'(1);
            r_sidx      <= w_search ? f_start_idx(w_len) : 3'd0;
            r_soct      <= w_search ? f_start_oct(w_len) : 8'sd1;
            r_best_dist <= '1;
        end
        if (i_cmd.cand_init) begin
            r_idx <= r_sidx;
            r_oct <= r_soct;
            r_rem <= 7'(r_len) * 7'(i_cfg.cycles);
            r_set <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.note_step) begin
            if (w_new) begin
                r_set[w_note[6:0]] <= 1'b1;
                r_sum <= r_sum + 13'(w_note[6:0]);
                r_cnt <= r_cnt + 8'd1;
            end
            if ({1'b0, r_idx} == r_len - 4'd1) begin
                r_idx <= 3'd0;
                r_oct <= r_oct + 8'sd1;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
            r_rem <= r_rem - 7'd1;
        end
        if (i_cmd.div_init) begin
            r_dq   <= {r_sum, 8'd0};
            r_drem <= '0;
            r_dcnt <= 5'(DIV_N);
        end
        if (i_cmd.div_step) begin
            r_drem <= w_ge ? 8'(w_trial - {1'b0, r_cnt}) : w_trial[7:0];
            r_dq   <= {r_dq[DIV_N-2:0], w_ge};
            r_dcnt <= r_dcnt - 5'd1;
        end
        if (i_cmd.cmp) begin
            if (w_dist < r_best_dist) begin
                r_best_dist <= w_dist;
                r_best_cent <= w_cc;
                r_best_set  <= r_set;
            end
            // next candidate starts one position higher
            if ({1'b0, r_sidx} == r_len - 4'd1) begin
                r_sidx <= 3'd0;
                r_soct <= r_soct + 8'sd1;
            end else begin
                r_sidx <= r_sidx + 3'd1;
            end
            r_cand <= r_cand - CAND_W'(1);
        end
        if (i_cmd.publish) begin
            r_out.notes_low  <= w_shifted[63:0];
            r_out.notes_high <= w_shifted[127:64];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cent <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.publish) begin
                r_last_cent <= r_best_cent;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.empty      = !w_slot_ok || (w_len == 4'd0);
    assign o_sts.build_done = (r_rem == 7'd0);
    assign o_sts.div_done   = (r_dcnt == 5'd0);
    assign o_sts.last_cand  = (r_cand == CAND_W'(1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_out            = r_out;
    assign o_out_valid      = r_out_valid;

endmodule

// ----- src/chord_voicing_nearest_inversion.sv -----
// Top level of the chord voicing block with nearest-inversion search:
// configuration registers, sequencer and datapath. Depends on cvni_pkg, cvni_ctrl and cvni_datapath.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   cvni_pkg::t_in  (base_note, slot_select)
//   out      output     o_out_valid / i_out_stall cvni_pkg::t_out (notes_low, notes_high)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item at a time. The sequencer builds K candidates, where K is the
// candidate count (INVERSION_COUNT when the search runs, else 1). Each one
// takes N notes, chord length times repeat count, one note per cycle, then
// the 21-step restoring divider for its centroid. An empty slot frees the
// input with no result. Reset is synchronous, active low, and clears the stored
// centroid of the last chord. A stalled result waits in the output register.
module chord_voicing_nearest_inversion #(
    parameter int CHORD_SLOTS     = cvni_pkg::CHORD_SLOTS_DEF,
    parameter int MAX_DIGITS      = cvni_pkg::MAX_DIGITS_DEF,
    parameter int INVERSION_COUNT = cvni_pkg::INVERSION_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cvni_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cvni_pkg::t_out                   o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cvni_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                      i_cfg_data
);
    import cvni_pkg::*;

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // Always ready; writes are expected only while no transaction is in flight.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.digits_lo <= RST_DIGITS;
            r_cfg.digits_hi <= RST_DIGITS;
            r_cfg.lengths   <= RST_LENGTHS;
            r_cfg.steps     <= RST_STEPS;
            r_cfg.scale_len <= RST_SCALE;
            r_cfg.octave    <= RST_OCTAVE;
            r_cfg.cycles    <= RST_CYCLES;
            r_cfg.inv_on    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIGITS_LO: r_cfg.digits_lo <= i_cfg_data;
                CFG_DIGITS_HI: r_cfg.digits_hi <= i_cfg_data;
                CFG_LENGTHS:   r_cfg.lengths   <= i_cfg_data[15:0];
                CFG_STEPS:     r_cfg.steps     <= i_cfg_data[47:0];
                CFG_SCALE_LEN: r_cfg.scale_len <= i_cfg_data[3:0];
                CFG_OCTAVE:    r_cfg.octave    <= i_cfg_data[2:0];
                CFG_CYCLES:    r_cfg.cycles    <= i_cfg_data[2:0];
                CFG_INV_ON:    r_cfg.inv_on    <= i_cfg_data[0];
                default:       ; // drop writes to unknown indexes
            endcase
        end
    end

    // Sequence each transaction: check slot, build candidates, divide, compare.
    cvni_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cvni_datapath #(
        .CHORD_SLOTS     (CHORD_SLOTS),
        .MAX_DIGITS      (MAX_DIGITS),
        .INVERSION_COUNT (INVERSION_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

`ifndef ASSERT_OFF
    // An accepted transaction makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off after accept");

    // A result is loaded only when the output register is free.
    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |-> (!o_out_valid || !i_out_stall))
        else $error("result overwrote a pending output");

    // Output valid comes up only from a publish.
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.publish))
        else $error("output valid without a result");
`endif

endmodule

// ----- bench/chord_voicing_nearest_inversion_test.sv -----
// Testbench for chord_voicing_nearest_inversion: a model of the chord voicing and inversion
// search drives an expected-result scoreboard. Depends on cvni_pkg and the block itself.
`timescale 1ns / 1ps

module chord_voicing_nearest_inversion_test;
    import cvni_pkg::*;

    // Scoreboard: keeps its own copy of the configuration and of the last chord, and
    // computes the expected voicing for each accepted transaction with a non-empty slot.
    class voicing_board;
        logic [63:0] digits_lo, digits_hi;
        logic [15:0] lengths;
        logic [47:0] steps;
        logic [3:0]  scale_len;
        logic [2:0]  octave, cycles;
        logic        inv_on;
        logic [127:0] prev_chord;
        t_out        voicings_due[$];
        int          errors;

        function void reset_state();
            digits_lo = RST_DIGITS; digits_hi = RST_DIGITS; lengths = RST_LENGTHS;
            steps = RST_STEPS; scale_len = RST_SCALE; octave = RST_OCTAVE;
            cycles = RST_CYCLES; inv_on = 1'b1; prev_chord = '0;
            voicings_due.delete(); errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
            case (idx)
                CFG_DIGITS_LO: digits_lo = v;
                CFG_DIGITS_HI: digits_hi = v;
                CFG_LENGTHS:   lengths = v[15:0];
                CFG_STEPS:     steps = v[47:0];
                CFG_SCALE_LEN: scale_len = v[3:0];
                CFG_OCTAVE:    octave = v[2:0];
                CFG_CYCLES:    cycles = v[2:0];
                CFG_INV_ON:    inv_on = v[0];
                default: ;
            endcase
        endfunction

        // Truncated Q7.8 mean note number, zero for an empty set.
        function int unsigned mean_q8(logic [127:0] s);
            int unsigned sum, cnt;
            sum = 0; cnt = 0;
            for (int n = 0; n < 128; n++) if (s[n]) begin sum += n; cnt++; end
            return cnt == 0 ? 0 : (sum * 256) / cnt;
        endfunction

        function logic [127:0] voice(int root, logic [31:0] dg, int len, int sclen, int inv);
            logic [127:0] s;
            int pos, oct, idx, d, note;
            s = '0;
            for (int k = 0; k < len * int'(cycles); k++) begin
                pos = k + inv + len * 100;
                oct = pos / len - 99;
                idx = pos % len;
                d = (dg >> (4 * idx)) & 15;
                note = int'((steps >> (4 * (d % sclen))) & 15) + root + oct * 12;
                if (note >= 0 && note < 128) s[note] = 1'b1;
            end
            return s;
        endfunction

        function void note_input(t_in t);
            int slot, len, sclen, shift;
            int unsigned target, best, c, gap;
            logic [31:0] dg;
            logic [127:0] b, cand;
            t_out o;
            slot = int'(t.slot_select) % 4;
            if (slot < 0) slot += 4;
            len = (lengths >> (4 * slot)) & 15;
            if (len > 8) len = 8;
            if (len == 0) return;               // empty slot: no result, state kept
            dg = (slot < 2 ? digits_lo : digits_hi) >> (32 * (slot & 1));
            sclen = scale_len == 0 ? 1 : (scale_len > 12 ? 12 : scale_len);
            target = mean_q8(prev_chord);
            if (inv_on && target * 100 >= 256) begin
                best = 32'hFFFF_FFFF;
                b = '0;
                for (int i = -5; i <= 5; i++) begin
                    cand = voice(t.base_note, dg, len, sclen, i);
                    c = mean_q8(cand);
                    gap = c > target ? c - target : target - c;
                    if (gap < best) begin best = gap; b = cand; end
                end
            end else begin
                b = voice(t.base_note, dg, len, sclen, 0);
            end
            prev_chord = b;
            shift = 12 * (int'(octave) + 2);
            o = '0;
            for (int n = 0; n + shift < 128; n++) begin
                if (b[n]) begin
                    if (n + shift < 64) o.notes_low[n + shift] = 1'b1;
                    else o.notes_high[n + shift - 64] = 1'b1;
                end
            end
            voicings_due.push_back(o);
        endfunction

        function void check_output(t_out got);
            t_out want;
            if (voicings_due.size() == 0) begin
                report_mismatch("result with nothing expected", 0, 0);
                return;
            end
            want = voicings_due.pop_front();
            if (got.notes_low !== want.notes_low)
                report_mismatch("notes_low", got.notes_low, want.notes_low);
            if (got.notes_high !== want.notes_high)
                report_mismatch("notes_high", got.notes_high, want.notes_high);
        endfunction

        function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s got %h want %h", what, got, want);
            errors++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    voicing_board board;
    int  cycle_count = 0;
    int  sent_items = 0;
    bit  hold_off_req = 1'b0;    // long receiver hold-off, asked for by the driver
    bit  calm_phase = 1'b0;      // stretch with no idling on either side

    localparam int CYCLE_LIMIT = 2_000_000;

    chord_voicing_nearest_inversion uut (.*);

    always #4 i_clk = ~i_clk;

    // Bound the run; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Sample results at the rising edge; check each accepted transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_output(o_out);
    end

    // Receiver stall: random idling, a calm stretch, and one long hold-off.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (3000) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            i_out_stall <= !calm_phase && ($urandom_range(99) < 36);
        end
    end

    // Write one register; hold until the block takes it, then drop valid.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one transaction; hold the payload while stalled. Valid stays up after
    // the accept until the next offer or an idle cycle replaces it.
    task automatic send_item(logic signed [7:0] root, logic signed [7:0] sel);
        t_in t;
        while (!calm_phase && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        t.base_note = root;
        t.slot_select = sel;
        i_in <= t;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(t);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Drop valid and drain before reconfiguring; an empty slot gives no result but may still keep the block busy.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.voicings_due.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic random_config(bit extreme);
        logic [63:0] r;
        r = {$urandom, $urandom};
        write_cfg(CFG_DIGITS_LO, extreme ? 64'hFFFF_FFFF_FFFF_FFFF : r);
        r = {$urandom, $urandom};
        write_cfg(CFG_DIGITS_HI, extreme ? 64'h0 : r);
        // Random chord lengths per slot, from empty up to past the length cap.
        r = 0;
        for (int s = 0; s < 4; s++) r[4*s +: 4] = extreme ? 4'hF : 4'($urandom_range(15));
        write_cfg(CFG_LENGTHS, r);
        write_cfg(CFG_STEPS, extreme ? 64'hFFFF_FFFF_FFFF : {16'h0, $urandom, 16'($urandom)});
        write_cfg(CFG_SCALE_LEN, extreme ? 64'(15) : 64'($urandom_range(15)));
        write_cfg(CFG_OCTAVE, extreme ? 64'(7) : 64'($urandom_range(7)));
        write_cfg(CFG_CYCLES, extreme ? 64'(4) : 64'($urandom_range(4)));
        write_cfg(CFG_INV_ON, 64'($urandom_range(1)));
    endtask

    initial begin
        board = new();
        board.reset_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset chords, field extremes, every slot, negative selectors.
        send_item(8'sd60, 8'sd0);
        send_item(8'sd60, 8'sd1);
        send_item(8'sd127, 8'sd2);
        send_item(-8'sd128, 8'sd3);
        send_item(-8'sd64, -8'sd1);
        send_item(8'sd0, -8'sd128);
        send_item(8'sd127, 8'sd127);
        send_item(-8'sd1, 8'sd0);
        drain();
        // Empty slots, zero cycles, inversions off, zero scale length.
        write_cfg(CFG_LENGTHS, 64'h0F80);
        write_cfg(CFG_CYCLES, 64'd0);
        send_item(8'sd40, 8'sd0);
        send_item(8'sd40, 8'sd1);
        send_item(8'sd40, 8'sd2);
        drain();
        write_cfg(CFG_CYCLES, 64'd4);
        write_cfg(CFG_SCALE_LEN, 64'd0);
        write_cfg(CFG_INV_ON, 64'd0);
        write_cfg(CFG_OCTAVE, 64'd0);
        send_item(8'sd10, 8'sd1);
        send_item(8'sd10, 8'sd2);
        send_item(-8'sd30, 8'sd3);
        drain();
        random_config(1'b1);
        for (int k = 0; k < 8; k++) send_item(8'($urandom), 8'($urandom));
        drain();

        // Random phases with fresh settings; one calm phase, one long hold-off.
        for (int ph = 0; ph < 22; ph++) begin
            random_config(1'b0);
            write_cfg(CFG_CYCLES, 64'($urandom_range(2)));
            calm_phase = (ph == 3);
            if (ph == 5) hold_off_req = 1'b1;
            for (int k = 0; k < 25; k++)
                send_item(8'($urandom_range(191) - 64), 8'($urandom));
            drain();
        end
        calm_phase = 1'b0;

        if (board.errors == 0 && board.voicings_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
src/cvni_pkg.sv
src/cvni_ctrl.sv
src/cvni_datapath.sv
src/chord_voicing_nearest_inversion.sv
bench/chord_voicing_nearest_inversion_test.sv
